[hw/rtl/symmetric_pair_commutator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric pair commutator
// Wrappers that compile to concurrent assertions, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_PAIR_COMMUTATOR_TOP_ASSERT_SVH
`define SYMMETRIC_PAIR_COMMUTATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define SPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("spc assertion failed");

// Condition must never be true outside reset
`define SPC_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("spc forbidden condition seen");

`else

`define SPC_ASSERT(lbl, clk, rst, prop)
`define SPC_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[hw/rtl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg
// Shared widths, word codes, command/status structs and the triangle-number
// helper for the symmetric pair commutator.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 6;
  localparam int DATA_W    = 32;
  localparam int OUT_IDX_W = 5;
  localparam int SIZE_W    = 4;
  localparam int ACC_W     = 64;

  // Widths that cover any supported matrix extent (up to 15)
  localparam int IDX_W  = 4;
  localparam int ADDR_W = 7;

  // Input word kinds
  localparam logic [KIND_W-1:0] KIND_WR_A    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // Extent after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // Controller to datapath
  typedef struct packed {
    logic wr_a;      // write element of A
    logic wr_b;      // write element of B
    logic issue;     // issue one pair of store reads
    logic sub;       // 0: A(i,j)*B(j,k) added, 1: B(i,j)*A(j,k) subtracted
    logic load_out;  // move finished sum into the output register
    logic last;      // element being loaded closes the triangle
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

  // x*(x+1)/2, start of row x in the packed lower triangle
  function automatic logic [ADDR_W-1:0] tri_num(input logic [IDX_W-1:0] x);
    logic [7:0] p;
    p = {4'd0, x} * ({4'd0, x} + 8'd1);
    return p[7:1];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/spc_ram.sv]
// ----------------------------------------------------------------------------
// spc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/spc_ctrl.sv]
// ----------------------------------------------------------------------------
// spc_ctrl
// Controller: extent register, input handshake and the walk over result
// rows, columns and inner terms.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_ctrl #(
  parameter int MAX_SIZE = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [spc_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  wire logic                         in_valid,
  input  wire logic [spc_pkg::KIND_W-1:0]   kind,
  output logic                              in_stall,
  output spc_pkg::dp_cmd_t                  cmd,
  input  wire spc_pkg::dp_status_t          status,
  output logic [$clog2(MAX_SIZE)-1:0]       row,
  output logic [$clog2(MAX_SIZE)-1:0]       col,
  output logic [$clog2(MAX_SIZE)-1:0]       inner
);

  localparam int IW = $clog2(MAX_SIZE);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [spc_pkg::SIZE_W-1:0]  matrix_size;
  logic [spc_pkg::SIZE_W-1:0]  n_eff;
  logic [IW-1:0]               n_m1;
  logic                        phase;
  logic [1:0]                  drain_cnt;
  logic                        start;
  logic                        row_end;
  logic                        last_elem;

  // Extent register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= spc_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      matrix_size <= cfg_wr_data;
    end
  end

  // Extent clamped to the store size
  assign n_eff = (matrix_size > spc_pkg::SIZE_W'(MAX_SIZE)) ?
                 spc_pkg::SIZE_W'(MAX_SIZE) : matrix_size;

  assign start = (state == ST_IDLE) && in_valid &&
                 (kind == spc_pkg::KIND_COMPUTE) && (n_eff >= 4'd2);

  assign row_end   = (col == row - IW'(1));
  assign last_elem = (row == n_m1) && row_end;

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.wr_a     = (state == ST_IDLE) && in_valid && (kind == spc_pkg::KIND_WR_A);
    cmd.wr_b     = (state == ST_IDLE) && in_valid && (kind == spc_pkg::KIND_WR_B);
    cmd.issue    = (state == ST_MAC);
    cmd.sub      = phase;
    cmd.load_out = (state == ST_EMIT) && status.out_free;
    cmd.last     = last_elem;
  end

  assign in_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (phase && (inner == n_m1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'd2) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = last_elem ? ST_IDLE : ST_MAC;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      col       <= '0;
      inner     <= '0;
      phase     <= 1'b0;
      drain_cnt <= '0;
      n_m1      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n_m1  <= IW'(n_eff - 4'd1);
            row   <= IW'(1);
            col   <= '0;
            inner <= '0;
            phase <= 1'b0;
          end
        end
        ST_MAC: begin
          phase <= ~phase;
          if (phase) begin
            if (inner == n_m1) begin
              inner     <= '0;
              drain_cnt <= '0;
            end else begin
              inner <= inner + IW'(1);
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 2'd1;
        end
        ST_EMIT: begin
          if (status.out_free && !last_elem) begin
            if (row_end) begin
              row <= row + IW'(1);
              col <= '0;
            end else begin
              col <= col + IW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spc_dpath.sv]
// ----------------------------------------------------------------------------
// spc_dpath
// Datapath: A and B stores, shared multiplier, rounding stage, 64-bit
// accumulator, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_dpath #(
  parameter int MAX_SIZE = 8,
  parameter int VW       = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spc_pkg::dp_cmd_t              cmd,
  output spc_pkg::dp_status_t                status,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   row,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   col,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   inner,
  input  wire logic [spc_pkg::INDEX_W-1:0]   elem_index,
  input  wire logic signed [spc_pkg::DATA_W-1:0] elem_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [spc_pkg::OUT_IDX_W-1:0]      out_index,
  output logic signed [spc_pkg::DATA_W-1:0]  out_value,
  output logic                               out_saturated,
  output logic                               out_last
);

  localparam int IW     = $clog2(MAX_SIZE);
  localparam int DEPTH  = MAX_SIZE * (MAX_SIZE + 1) / 2;
  localparam int AW     = $clog2(DEPTH);
  localparam int ELEM_W = $clog2(MAX_SIZE * (MAX_SIZE - 1) / 2 + 1);
  localparam logic signed [spc_pkg::ACC_W-1:0] MAXV =
    (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [spc_pkg::ACC_W-1:0] MINV = -MAXV - 64'sd1;

  logic                 in_range;
  logic [AW-1:0]        addr_ij;
  logic [AW-1:0]        addr_jk;
  logic [IW-1:0]        hi_ij, lo_ij, hi_jk, lo_jk;
  logic [AW-1:0]        a_raddr, b_raddr;
  logic [VW-1:0]        a_rdata, b_rdata;

  logic                             s1_valid, s1_sub;
  logic                             s2_valid, s2_sub;
  logic                             s3_valid, s3_sub;
  logic signed [2*VW-1:0]           prod;
  logic signed [spc_pkg::ACC_W-1:0] prod_ext;
  logic signed [spc_pkg::ACC_W-1:0] term;
  logic signed [spc_pkg::ACC_W-1:0] acc;
  logic                             sat_hi, sat_lo;
  logic signed [spc_pkg::ACC_W-1:0] clamped;
  logic [ELEM_W-1:0]                out_cnt;

  // Writes beyond the store are dropped
  assign in_range = (spc_pkg::ADDR_W'(elem_index) < spc_pkg::ADDR_W'(DEPTH));

  // Packed addresses of the symmetric elements (i,j) and (j,k)
  always_comb begin
    hi_ij   = (row >= inner) ? row : inner;
    lo_ij   = (row >= inner) ? inner : row;
    hi_jk   = (inner >= col) ? inner : col;
    lo_jk   = (inner >= col) ? col : inner;
    addr_ij = AW'(spc_pkg::tri_num(spc_pkg::IDX_W'(hi_ij)) +
                  spc_pkg::ADDR_W'(lo_ij));
    addr_jk = AW'(spc_pkg::tri_num(spc_pkg::IDX_W'(hi_jk)) +
                  spc_pkg::ADDR_W'(lo_jk));
  end

  // Phase 0 reads A(i,j), B(j,k); phase 1 reads A(j,k), B(i,j)
  assign a_raddr = cmd.sub ? addr_jk : addr_ij;
  assign b_raddr = cmd.sub ? addr_ij : addr_jk;

  spc_ram #(.WIDTH(VW), .DEPTH(DEPTH)) a_ram (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (AW'(elem_index)),
    .wdata (elem_value[VW-1:0]),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  spc_ram #(.WIDTH(VW), .DEPTH(DEPTH)) b_ram (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (AW'(elem_index)),
    .wdata (elem_value[VW-1:0]),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign prod_ext = spc_pkg::ACC_W'(prod);

  // Multiply, round half up to Q16.16, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_sub <= cmd.sub;
    s2_sub <= s1_sub;
    s3_sub <= s2_sub;
    prod   <= signed'(a_rdata) * signed'(b_rdata);
    term   <= (prod_ext + 64'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= s3_sub ? (acc - term) : (acc + term);
    end
  end

  // Saturation to the value range
  always_comb begin
    sat_hi  = (acc > MAXV);
    sat_lo  = (acc < MINV);
    clamped = sat_hi ? MAXV : (sat_lo ? MINV : acc);
  end

  assign status.out_free = !out_valid || !out_stall;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_cnt   <= '0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
      out_cnt   <= cmd.last ? '0 : out_cnt + ELEM_W'(1);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_index     <= spc_pkg::OUT_IDX_W'(out_cnt);
      out_value     <= clamped[spc_pkg::DATA_W-1:0];
      out_saturated <= sat_hi || sat_lo;
      out_last      <= cmd.last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/symmetric_pair_commutator_top.sv]
// ----------------------------------------------------------------------------
// symmetric_pair_commutator_top
// Commutator A*B - B*A of two packed symmetric matrices, emitted as the
// strictly lower triangle of the antisymmetric result.
// Element writes: one word per cycle while no compute is running, no result.
// Compute: each result element takes 2n reads through the one shared multiplier,
//   a drain through the pipeline and one load; n(n-1)/2 elements in all.
// Reset: extent 8, controller idle, output empty; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "symmetric_pair_commutator_top_assert.svh"

module symmetric_pair_commutator_top #(
  parameter int MAX_SIZE    = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [spc_pkg::SIZE_W-1:0]         cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [spc_pkg::KIND_W-1:0]         kind,
  input  wire logic [spc_pkg::INDEX_W-1:0]        elem_index,
  input  wire logic signed [spc_pkg::DATA_W-1:0]  elem_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [spc_pkg::OUT_IDX_W-1:0]           out_index,
  output logic signed [spc_pkg::DATA_W-1:0]       out_value,
  output logic                                    out_saturated,
  output logic                                    out_last
);

  // Stored value width, held to 16..32
  localparam int VW = (VALUE_WIDTH < 16) ? 16 :
                      ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);
  localparam int IW = $clog2(MAX_SIZE);

  spc_pkg::dp_cmd_t    cmd;
  spc_pkg::dp_status_t status;
  logic [IW-1:0]       row;
  logic [IW-1:0]       col;
  logic [IW-1:0]       inner;

  spc_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .kind        (kind),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .status      (status),
    .row         (row),
    .col         (col),
    .inner       (inner)
  );

  spc_dpath #(.MAX_SIZE(MAX_SIZE), .VW(VW)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .row           (row),
    .col           (col),
    .inner         (inner),
    .elem_index    (elem_index),
    .elem_value    (elem_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_index     (out_index),
    .out_value     (out_value),
    .out_saturated (out_saturated),
    .out_last      (out_last)
  );

  // Checks
  `SPC_ASSERT(a_load_needs_room, clk, rst, cmd.load_out |-> status.out_free)
  `SPC_ASSERT(a_write_not_in_walk, clk, rst, (cmd.wr_a || cmd.wr_b) |-> !cmd.issue)
  `SPC_ASSERT(a_idle_after_last, clk, rst, (cmd.load_out && cmd.last) |=> !in_stall)
  `SPC_ASSERT_NEVER(a_issue_while_load, clk, rst, cmd.issue && cmd.load_out)

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for symmetric_pair_commutator_top. Loads the packed A
// and B triangles, issues compute words, and compares every emitted element of
// the commutator A*B - B*A against an in-bench fixed-point predictor. Both
// handshakes take random gaps; one phase backs up the output on purpose.
// ----------------------------------------------------------------------------

module tb_top;
  import spc_pkg::*;

  localparam int                  STORE_SLOTS  = 36;   // 8*9/2 packed entries
  localparam int                  SETTLE_CYC   = 40;   // outlasts one result element at extent 8
  localparam logic [KIND_W-1:0]   KIND_UNUSED  = 2'd3;
  localparam longint              SUM_MAX      = 64'sh7FFF_FFFF;
  localparam longint              SUM_MIN      = -64'sh8000_0000;

  // One emitted element of the antisymmetric result
  typedef struct {
    logic [OUT_IDX_W-1:0]     idx;
    logic signed [DATA_W-1:0] val;
    logic                     sat;
    logic                     last;
  } comm_elem_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]          cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [KIND_W-1:0]          kind = KIND_WR_A;
  logic [INDEX_W-1:0]         elem_index = '0;
  logic signed [DATA_W-1:0]   elem_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [OUT_IDX_W-1:0]       out_index;
  logic signed [DATA_W-1:0]   out_value;
  logic                       out_saturated;
  logic                       out_last;

  // Predictor state
  logic signed [DATA_W-1:0]   a_mat [STORE_SLOTS];
  logic signed [DATA_W-1:0]   b_mat [STORE_SLOTS];
  bit                         a_set [STORE_SLOTS];
  bit                         b_set [STORE_SLOTS];
  logic [SIZE_W-1:0]          extent_now = SIZE_RESET;
  comm_elem_t                 pending_elems[$];

  // Run bookkeeping
  int  errors = 0;
  int  words_sent = 0;
  int  elems_checked = 0;
  int  sat_seen = 0;
  int  compute_passes = 0;
  int  hold_cycles = 0;
  bit  no_gaps = 1'b0;
  bit  extents_seen [16];

  symmetric_pair_commutator_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .elem_index    (elem_index),
    .elem_value    (elem_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_index     (out_index),
    .out_value     (out_value),
    .out_saturated (out_saturated),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // Symmetric element (r, c) read from a packed lower triangle
  function automatic logic signed [DATA_W-1:0] sym_elem(input bit from_b, input int r,
                                                        input int c);
    int hi;
    int lo;
    hi = (r >= c) ? r : c;
    lo = (r >= c) ? c : r;
    return from_b ? b_mat[hi * (hi + 1) / 2 + lo] : a_mat[hi * (hi + 1) / 2 + lo];
  endfunction

  // Q16.16 product, rounded half up
  function automatic longint round_mul(input logic signed [DATA_W-1:0] x,
                                       input logic signed [DATA_W-1:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // Expected elements of one compute word at the current extent
  function automatic void predict_commutator();
    int         n;
    int         cnt;
    int         total;
    longint     acc;
    comm_elem_t e;
    n = (extent_now > 8) ? 8 : int'(extent_now);
    if (n < 2) return;
    total = n * (n - 1) / 2;
    cnt = 0;
    for (int i = 1; i < n; i++) begin
      for (int k = 0; k < i; k++) begin
        acc = 0;
        for (int j = 0; j < n; j++) begin
          acc += round_mul(sym_elem(0, i, j), sym_elem(1, j, k));
          acc -= round_mul(sym_elem(1, i, j), sym_elem(0, j, k));
        end
        e.sat = 1'b0;
        if (acc > SUM_MAX) begin
          e.val = 32'h7FFF_FFFF;
          e.sat = 1'b1;
        end else if (acc < SUM_MIN) begin
          e.val = 32'h8000_0000;
          e.sat = 1'b1;
        end else begin
          e.val = acc[DATA_W-1:0];
        end
        e.idx  = OUT_IDX_W'(i * (i - 1) / 2 + k);
        cnt++;
        e.last = (cnt == total);
        pending_elems.push_back(e);
      end
    end
  endfunction

  // Update the model with one accepted input word
  function automatic void apply_word(input logic [KIND_W-1:0] k, input int addr,
                                     input logic signed [DATA_W-1:0] v);
    case (k)
      KIND_WR_A: begin
        if (addr < STORE_SLOTS) begin
          a_mat[addr] = v;
          a_set[addr] = 1'b1;
        end
      end
      KIND_WR_B: begin
        if (addr < STORE_SLOTS) begin
          b_mat[addr] = v;
          b_set[addr] = 1'b1;
        end
      end
      KIND_COMPUTE: begin
        compute_passes++;
        predict_commutator();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  // Compare each accepted element with the oldest expectation
  always @(posedge clk) begin
    comm_elem_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        errors++;
        $display("%0t: unexpected element idx=%0d val=%h sat=%b last=%b", $time,
                 out_index, out_value, out_saturated, out_last);
      end else begin
        e = pending_elems.pop_front();
        elems_checked++;
        if (out_saturated) sat_seen++;
        if (out_index !== e.idx) begin
          errors++;
          $display("%0t: out_index expected %0d actual %0d", $time, e.idx, out_index);
        end
        if (out_value !== e.val) begin
          errors++;
          $display("%0t: out_value (idx %0d) expected %h actual %h", $time, e.idx, e.val,
                   out_value);
        end
        if (out_saturated !== e.sat) begin
          errors++;
          $display("%0t: out_saturated (idx %0d) expected %b actual %b", $time, e.idx,
                   e.sat, out_saturated);
        end
        if (out_last !== e.last) begin
          errors++;
          $display("%0t: out_last (idx %0d) expected %b actual %b", $time, e.idx, e.last,
                   out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Random stall before each element; a requested hold-off is counted here
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------- sender

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [KIND_W-1:0] k, input int addr,
                           input logic signed [DATA_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    elem_index <= addr[INDEX_W-1:0];
    elem_value <= v;
    do @(posedge clk); while (in_stall);
    apply_word(k, addr, v);
    if (k == KIND_COMPUTE || (k != KIND_UNUSED && addr < STORE_SLOTS)) words_sent++;
  endtask

  // Stop offering, let every expected element arrive, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write the extent register while idle
  task automatic set_extent(input logic [SIZE_W-1:0] n);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    extent_now = n;
    extents_seen[n] = 1'b1;
  endtask

  // Value classes: 0 about +-4.0, 1 full range, 2 extremes, 3 small fractions
  function automatic logic signed [DATA_W-1:0] draw_value(input int mode);
    logic [31:0] r;
    r = $urandom;
    case (mode)
      0: return {{13{r[18]}}, r[18:0]};
      1: return r;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return {{16{r[16]}}, r[15:0]};
    endcase
  endfunction

  // Write every entry of both triangles that an extent of n would read and that is not yet set
  task automatic fill_missing(input int n, input int mode);
    int depth;
    bit b_first;
    depth = n * (n + 1) / 2;
    for (int ad = 0; ad < depth; ad++) begin
      b_first = $urandom_range(0, 1);
      if (b_first && !b_set[ad]) send_word(KIND_WR_B, ad, draw_value(mode));
      if (!a_set[ad]) send_word(KIND_WR_A, ad, draw_value(mode));
      if (!b_set[ad]) send_word(KIND_WR_B, ad, draw_value(mode));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Extent 2: saturation both ways and rounding of half an lsb both ways
  task automatic test_directed_extremes();
    set_extent(4'd2);
    send_word(KIND_WR_A, 0, 32'h7FFF_FFFF);
    send_word(KIND_WR_A, 1, 32'h0000_0000);
    send_word(KIND_WR_A, 2, 32'h8000_0000);
    send_word(KIND_WR_B, 0, 32'h0000_0000);
    send_word(KIND_WR_B, 1, 32'h7FFF_FFFF);
    send_word(KIND_WR_B, 2, 32'h0000_0000);
    send_word(KIND_COMPUTE, 0, 32'h0);   // large negative sum
    send_word(KIND_WR_B, 1, 32'h8000_0000);
    send_word(KIND_COMPUTE, 0, 32'h0);   // large positive sum
    send_word(KIND_WR_A, 0, 32'h0000_8000);
    send_word(KIND_WR_A, 2, 32'h0000_0000);
    send_word(KIND_WR_B, 1, 32'h0000_0001);
    send_word(KIND_COMPUTE, 0, 32'h0);   // half lsb rounds up
    send_word(KIND_WR_B, 1, 32'hFFFF_FFFF);
    send_word(KIND_WR_A, 1, 32'h0001_0000);
    send_word(KIND_COMPUTE, 0, 32'h0);   // negative half lsb rounds to zero
  endtask

  // Unused kind, writes past the store, and extents too small for a triangle
  task automatic test_ignored_and_empty();
    send_word(KIND_UNUSED, 63, 32'hFFFF_FFFF);
    send_word(KIND_WR_A, 36, 32'h1234_5678);
    send_word(KIND_WR_B, 63, 32'h8765_4321);
    send_word(KIND_COMPUTE, 63, 32'hFFFF_FFFF);
    set_extent(4'd0);
    send_word(KIND_COMPUTE, 0, 32'h0);
    set_extent(4'd1);
    send_word(KIND_WR_A, 0, 32'h0002_0000);
    send_word(KIND_COMPUTE, 0, 32'h0);
  endtask

  // Load-then-compute sequences with random content over several extents
  task automatic test_random_sequences();
    int stop_at;
    int phase;
    int n;
    int mode;
    int depth;
    stop_at = words_sent + 100;
    phase = 0;
    while (words_sent < stop_at) begin
      case (phase)
        0: set_extent(4'd3);
        1: set_extent(4'd8);
        2: set_extent(4'd15);
        default: begin
          case ($urandom_range(0, 9))
            0: set_extent(4'd0);
            1: set_extent(4'd1);
            2, 3: set_extent(4'd2);
            4, 5: set_extent(4'd3);
            6, 7: set_extent(4'd4);
            8: set_extent(4'd5);
            default: set_extent(4'(9 + $urandom_range(0, 6)));
          endcase
        end
      endcase
      phase++;
      n = (extent_now > 8) ? 8 : int'(extent_now);
      depth = n * (n + 1) / 2;
      repeat ($urandom_range(1, 3)) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        mode = $urandom_range(0, 4);   // 4: class drawn afresh per fill and per extra word
        fill_missing(n, (mode == 4) ? $urandom_range(0, 3) : mode);
        if (depth > 0) begin
          repeat ($urandom_range(0, 4))
            send_word($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A,
                      $urandom_range(0, depth - 1),
                      draw_value((mode == 4) ? $urandom_range(0, 3) : mode));
        end
        if ($urandom_range(0, 4) == 0)
          send_word(KIND_UNUSED, $urandom_range(0, 63), $urandom);
        if ($urandom_range(0, 4) == 0)
          send_word($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A,
                    $urandom_range(STORE_SLOTS, 63), $urandom);
        send_word(KIND_COMPUTE, $urandom_range(0, 63), $urandom);
        if ($urandom_range(0, 3) == 0) send_word(KIND_COMPUTE, 0, 32'h0);
        no_gaps = 1'b0;
      end
    end
  endtask

  // Long receiver hold-off while words keep coming, then a full pause
  task automatic test_output_backpressure();
    set_extent(4'd8);
    fill_missing(8, 0);
    hold_cycles = 400;
    send_word(KIND_COMPUTE, 0, 32'h0);
    repeat (5)
      send_word($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A,
                $urandom_range(0, STORE_SLOTS - 1), draw_value(0));
    send_word(KIND_COMPUTE, 0, 32'h0);
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_ignored_and_empty();
    test_random_sequences();
    test_output_backpressure();
    wait_idle();
    $display("Run covered %0d words, %0d compute passes, %0d elements checked (%0d saturated)",
             words_sent, compute_passes, elems_checked, sat_seen);
    $display("Extents 0, 1, 2, 8 and 15 exercised: %b%b%b%b%b", extents_seen[0],
             extents_seen[1], extents_seen[2], extents_seen[8], extents_seen[15]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d elements outstanding", pending_elems.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/spc_pkg.sv
hw/rtl/spc_ram.sv
hw/rtl/spc_ctrl.sv
hw/rtl/spc_dpath.sv
hw/rtl/symmetric_pair_commutator_top.sv
tb/tb_top.sv
